@@ sv/spk_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and round functions for the speck48/96 cipher
package spk_pkg;

    localparam int W          = 24;
    localparam int ROUNDS_DEF = 23;
    localparam int AW         = 4;
    localparam int DW         = 32;

    typedef logic [W-1:0] t_word;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef struct packed {
        logic  cmd;
        t_word lo;
        t_word hi;
    } t_blk;

    typedef struct packed {
        logic          psel;
        logic          penable;
        logic          pwrite;
        logic [AW-1:0] paddr;
        logic [DW-1:0] pwdata;
    } t_apb_req;

    function automatic t_word rotl3(input t_word x);
        return {x[W-4:0], x[W-1:W-3]};
    endfunction

    function automatic t_word rotl8(input t_word x);
        return {x[W-9:0], x[W-1:W-8]};
    endfunction

    function automatic t_word rotl16(input t_word x);
        return {x[W-17:0], x[W-1:W-16]};
    endfunction

    function automatic t_word rotl21(input t_word x);
        return {x[W-22:0], x[W-1:W-21]};
    endfunction

    function automatic t_blk enc_round(input t_blk b, input t_word rk);
        t_blk r;
        r     = b;
        r.lo  = (rotl16(b.lo) + b.hi) ^ rk;
        r.hi  = rotl3(b.hi) ^ r.lo;
        return r;
    endfunction

    function automatic t_blk dec_round(input t_blk b, input t_word rk);
        t_blk r;
        r     = b;
        r.hi  = rotl21(b.hi ^ b.lo);
        r.lo  = rotl8((b.lo ^ rk) - r.hi);
        return r;
    endfunction

endpackage

@@ sv/spk_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for input blocks and result blocks
interface spk_in_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [spk_pkg::W-1:0] block_lo;
    logic [spk_pkg::W-1:0] block_hi;

    modport source (output valid, output cmd, output block_lo, output block_hi, input ready);
    modport sink (input valid, input cmd, input block_lo, input block_hi, output ready);
endinterface

interface spk_out_if;
    logic                valid;
    logic                ready;
    logic [spk_pkg::W-1:0] result_lo;
    logic [spk_pkg::W-1:0] result_hi;

    modport source (output valid, output result_lo, output result_hi, input ready);
    modport sink (input valid, input result_lo, input result_hi, output ready);
endinterface

@@ sv/spk_key_sched.sv @@
`timescale 1ns / 1ps
// key registers, register port decode and iterative round key expansion
module spk_key_sched #(
    parameter int ROUNDS = spk_pkg::ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spk_pkg::t_apb_req     i_apb,
    output logic [spk_pkg::DW-1:0] o_prdata,
    output logic                  o_busy,
    output spk_pkg::t_word        o_rk [ROUNDS]
);
    import spk_pkg::*;

    localparam int CW   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int LAST = (ROUNDS > 1) ? ROUNDS - 2 : 0;

    t_word          r_key [4];
    logic           r_start;
    logic           r_busy;
    logic [CW-1:0]  r_cnt;
    t_word          r_s0, r_s1, r_s2;
    t_word          r_cur;
    t_word          r_rk [ROUNDS];

    logic           wr;
    t_reg_idx       ridx;
    t_word          m;
    t_word          nxt;

    always_comb begin
        wr   = i_apb.psel & i_apb.penable & i_apb.pwrite;
        ridx = t_reg_idx'(i_apb.paddr[3:2]);
        m    = (rotl16(r_s0) + r_cur) ^ W'(r_cnt);
        nxt  = rotl3(r_cur) ^ m;
    end

    always_comb begin
        unique case (ridx)
            REG_KEY0: o_prdata = DW'(r_key[0]);
            REG_KEY1: o_prdata = DW'(r_key[1]);
            REG_KEY2: o_prdata = DW'(r_key[2]);
            REG_KEY3: o_prdata = DW'(r_key[3]);
            default:  o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
        end else if (wr) begin
            r_key[ridx] <= i_apb.pwdata[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_start <= wr;
            if (r_start) begin
                r_busy <= (ROUNDS > 1);
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(LAST)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_start) begin
            r_s0     <= r_key[1];
            r_s1     <= r_key[2];
            r_s2     <= r_key[3];
            r_cur    <= r_key[0];
            r_rk[0]  <= r_key[0];
        end else if (r_busy) begin
            r_s0                 <= r_s1;
            r_s1                 <= r_s2;
            r_s2                 <= m;
            r_cur                <= nxt;
            r_rk[r_cnt + CW'(1)] <= nxt;
        end
    end

    assign o_busy = r_start | r_busy;
    assign o_rk   = r_rk;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= CW'(LAST)))
        else $error("key expansion counter past last step");

    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |=> o_busy)
        else $error("key write did not restart expansion");
`endif

endmodule

@@ sv/spk_round.sv @@
`timescale 1ns / 1ps
// one pipelined cipher round, encrypt or decrypt by the word's command bit
module spk_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  spk_pkg::t_blk  i_blk,
    input  spk_pkg::t_word i_rk_enc,
    input  spk_pkg::t_word i_rk_dec,
    output logic           o_valid,
    output spk_pkg::t_blk  o_blk
);
    import spk_pkg::*;

    logic r_valid;
    t_blk r_blk;
    t_blk n_blk;

    always_comb begin
        if (i_blk.cmd == CMD_DEC) begin
            n_blk = dec_round(i_blk, i_rk_dec);
        end else begin
            n_blk = enc_round(i_blk, i_rk_enc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

@@ sv/spk_outbuf.sv @@
`timescale 1ns / 1ps
// output register with one skid entry, decouples the pipeline from the receiver
module spk_outbuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  spk_pkg::t_blk  i_blk,
    output logic           o_en,
    spk_out_if.source      o_out
);
    import spk_pkg::*;

    logic  r_out_v, r_sk_v;
    t_blk  r_out, r_sk;
    logic  n_out_v, n_sk_v;
    t_blk  n_out, n_sk;
    logic  take;
    logic  arrive;

    always_comb begin
        o_en    = !r_sk_v;
        take    = r_out_v & o_out.ready;
        arrive  = i_valid & o_en;
        n_out_v = r_out_v;
        n_sk_v  = r_sk_v;
        n_out   = r_out;
        n_sk    = r_sk;
        if (r_sk_v) begin
            if (take) begin
                n_out  = r_sk;
                n_sk_v = 1'b0;
            end
        end else if (arrive) begin
            if (!r_out_v || take) begin
                n_out   = i_blk;
                n_out_v = 1'b1;
            end else begin
                n_sk   = i_blk;
                n_sk_v = 1'b1;
            end
        end else if (take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            r_sk_v  <= n_sk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sk  <= n_sk;
    end

    assign o_out.valid     = r_out_v;
    assign o_out.result_lo = r_out.lo;
    assign o_out.result_hi = r_out.hi;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && !o_out.ready) |=> (r_sk_v && r_out_v && $stable(r_sk)))
        else $error("skid entry changed while receiver stalled");
`endif

endmodule

@@ sv/speck48_96_block_cipher_top.sv @@
`timescale 1ns / 1ps
// speck48/96 block cipher, one round per pipeline stage
//
// usage:
//   key words 0..3 are written through the register port at byte addresses
//   0, 4, 8 and 12; pready is always high and reads return the key words.
//   input words (cmd, block_lo, block_hi) enter on i_blk, cmd 0 encrypts and
//   cmd 1 decrypts; result words leave on o_blk in the order they entered.
// throughput: one word per cycle outside key expansion and output stalls, set by one round per pipeline stage.
// path: from input acceptance to output valid, a word passes through ROUNDS
//   round stages followed by the output register.
// key expansion: after reset and after every key write, the round keys are
//   rebuilt one per cycle by a single expansion step; i_blk.ready stays low
//   while this runs.
// reset: clears key words to zero, empties the pipeline and output buffer.
// stall: when the receiver holds ready low, the output register and one skid
//   entry fill; the round pipeline then freezes and i_blk.ready drops. no
//   word is lost or repeated.
module speck48_96_block_cipher_top #(
    parameter int ROUNDS = spk_pkg::ROUNDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    spk_in_if.sink                 i_blk,
    spk_out_if.source              o_blk,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [spk_pkg::AW-1:0] paddr,
    input  logic [spk_pkg::DW-1:0] pwdata,
    output logic [spk_pkg::DW-1:0] prdata,
    output logic                   pready
);
    import spk_pkg::*;

    t_apb_req apb;
    logic     key_busy;
    t_word    rk [ROUNDS];
    logic     pipe_en;
    logic     st_valid [ROUNDS+1];
    t_blk     st_blk [ROUNDS+1];

    assign apb.psel    = psel;
    assign apb.penable = penable;
    assign apb.pwrite  = pwrite;
    assign apb.paddr   = paddr;
    assign apb.pwdata  = pwdata;
    assign pready      = 1'b1;

    spk_key_sched #(
        .ROUNDS (ROUNDS)
    ) u_key_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apb    (apb),
        .o_prdata (prdata),
        .o_busy   (key_busy),
        .o_rk     (rk)
    );

    assign i_blk.ready   = pipe_en & !key_busy;
    assign st_valid[0]   = i_blk.valid & i_blk.ready;
    assign st_blk[0].cmd = i_blk.cmd;
    assign st_blk[0].lo  = i_blk.block_lo;
    assign st_blk[0].hi  = i_blk.block_hi;

    for (genvar j = 0; j < ROUNDS; j++) begin : g_round
        spk_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (pipe_en),
            .i_valid  (st_valid[j]),
            .i_blk    (st_blk[j]),
            .i_rk_enc (rk[j]),
            .i_rk_dec (rk[ROUNDS-1-j]),
            .o_valid  (st_valid[j+1]),
            .o_blk    (st_blk[j+1])
        );
    end

    spk_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[ROUNDS]),
        .i_blk   (st_blk[ROUNDS]),
        .o_en    (pipe_en),
        .o_out   (o_blk)
    );

endmodule
